>>> design/tkns_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tkns_pkg: shared types and constants of the top-k nearest selector
// distance coding, readout field widths, cell control bundle and fsm states
// ---------------------------------------------------------------------------
package tkns_pkg;

    localparam int DIST_W   = 32;
    localparam int KEEP_W   = 5;
    localparam int RANK_W   = 4;
    localparam int FOUND_W  = 5;

    localparam int DEFAULT_LIST_DEPTH = 16;
    localparam int DEFAULT_ID_WIDTH   = 16;

    localparam logic [DIST_W-1:0] EMPTY_DIST = 32'hFFFF_FFFF;
    localparam logic [DIST_W-1:0] CLAMP_DIST = 32'hFFFF_FFFE;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    // per-cell control from the list sequencer
    typedef struct packed {
        logic occupied;    // cell holds a live entry of this pass
        logic worst_full;  // cell is the worst slot of a full list
        logic ins_en;      // an item is being inserted this cycle
        logic shift_up;    // readout: move entries one rank toward the head
    } cell_ctrl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_READOUT
    } list_state_t;

endpackage : tkns_pkg
`default_nettype wire

>>> design/top_k_nearest_sorted_select.sv
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_nearest_sorted_select: streaming top-k smallest-distance selector
// keeps the keep_count nearest items of a pass in a sorted row of cells and
// reads them out in rank order when the last item of the pass arrives
// ---------------------------------------------------------------------------
// Items (id, distance, last) enter one per cycle on the s_ channel outside
// readout. Each item is broadcast to a row of LIST_DEPTH cells that compare
// it with their entry in parallel and shift in one step. An item with last
// is inserted in its cycle, then the list is streamed out on the m_ channel
// from the head cell, one entry per cycle while m_ready is high; the input
// stays closed during that readout. Equal distances keep arrival order,
// except that a full list replaces its worst entry by a newer item of
// equal distance. An all-ones distance is taken as all-ones minus one.
// keep_count (cfg_data) is clamped to 1..LIST_DEPTH; the user must write it
// only between passes, as the block itself does not enforce this. No
// clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module top_k_nearest_sorted_select
    import tkns_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int ID_WIDTH   = DEFAULT_ID_WIDTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    // configuration: keep_count
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [KEEP_W-1:0]    cfg_data,
    // item input
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire [ID_WIDTH-1:0]  s_candidate_id,
    input  wire [DIST_W-1:0]    s_distance,
    input  wire                 s_last,
    // result output
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [RANK_W-1:0]   m_rank,
    output logic [ID_WIDTH-1:0] m_result_id,
    output logic [DIST_W-1:0]   m_result_distance,
    output logic [FOUND_W-1:0]  m_found_count,
    output logic                m_final_of_run
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    list_state_t         state_reg, state_next;
    logic [KEEP_W-1:0]   keep_count_reg;
    logic [CNT_W-1:0]    filled_reg, filled_next;
    logic [CNT_W-1:0]    rank_reg, rank_next;

    logic [CNT_W-1:0]    k_eff;        // clamped keep count
    logic [CNT_W-1:0]    filled_eff;   // fill level cut to the current limit
    logic [DIST_W-1:0]   cand_dist;
    logic                in_fire, out_fire, last_out;
    logic                ins_en, shift_up;

    cell_ctrl_t          cell_ctrl [LIST_DEPTH];
    logic                cell_gt   [LIST_DEPTH];
    logic [DIST_W-1:0]   cell_dist [LIST_DEPTH];
    logic [ID_WIDTH-1:0] cell_id   [LIST_DEPTH];

    logic [31:0]         rank_wide, found_wide;

    // config write, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= KEEP_RESET;
        end else if (cfg_valid) begin
            keep_count_reg <= cfg_data;
        end
    end

    // keep count limited to 1..LIST_DEPTH
    always_comb begin
        if (keep_count_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if (32'(keep_count_reg) > 32'(LIST_DEPTH)) begin
            k_eff = CNT_W'(LIST_DEPTH);
        end else begin
            k_eff = CNT_W'(keep_count_reg);
        end
    end

    // a lowered limit drops the worst entries
    assign filled_eff = (filled_reg > k_eff) ? k_eff : filled_reg;

    // all-ones is the empty marker, never a real distance
    assign cand_dist = (s_distance == EMPTY_DIST) ? CLAMP_DIST : s_distance;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign last_out = (rank_reg == filled_reg - CNT_W'(1));

    // sequencer: collect items, then drain the list from the head cell
    always_comb begin
        state_next  = state_reg;
        filled_next = filled_reg;
        rank_next   = rank_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        ins_en      = 1'b0;
        shift_up    = 1'b0;
        unique case (state_reg)
            ST_COLLECT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ins_en      = 1'b1;
                    filled_next = (filled_eff < k_eff) ? filled_eff + CNT_W'(1) : k_eff;
                    rank_next   = '0;
                    if (s_last) begin
                        state_next = ST_READOUT;
                    end
                end
            end
            ST_READOUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    shift_up  = 1'b1;
                    rank_next = rank_reg + CNT_W'(1);
                    if (last_out) begin
                        // list cleared for the next pass
                        filled_next = '0;
                        state_next  = ST_COLLECT;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_COLLECT;
            filled_reg <= '0;
            rank_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            rank_reg   <= rank_next;
        end
    end

    // per-cell control: live entries and the worst slot of a full list
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            cell_ctrl[i].occupied   = (CNT_W'(i) < filled_eff);
            cell_ctrl[i].worst_full = (CNT_W'(i) == k_eff - CNT_W'(1)) &&
                                      (filled_eff == k_eff);
            cell_ctrl[i].ins_en     = ins_en;
            cell_ctrl[i].shift_up   = shift_up;
        end
    end

    // row of cells: insertion shifts toward the tail, readout toward the head
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic                prev_gt;
        logic [DIST_W-1:0]   prev_dist, next_dist;
        logic [ID_WIDTH-1:0] prev_id, next_id;

        if (g == 0) begin : g_head
            assign prev_gt   = 1'b0;
            assign prev_dist = EMPTY_DIST;
            assign prev_id   = '0;
        end else begin : g_body
            assign prev_gt   = cell_gt[g-1];
            assign prev_dist = cell_dist[g-1];
            assign prev_id   = cell_id[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_tail
            assign next_dist = EMPTY_DIST;
            assign next_id   = '0;
        end else begin : g_inner
            assign next_dist = cell_dist[g+1];
            assign next_id   = cell_id[g+1];
        end

        tkns_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[g]),
            .cand_dist (cand_dist),
            .cand_id   (s_candidate_id),
            .prev_gt   (prev_gt),
            .prev_dist (prev_dist),
            .prev_id   (prev_id),
            .next_dist (next_dist),
            .next_id   (next_id),
            .gt        (cell_gt[g]),
            .held_dist (cell_dist[g]),
            .id        (cell_id[g])
        );
    end

    // result fields straight from the head cell and the sequencer registers
    assign rank_wide  = 32'(rank_reg);
    assign found_wide = 32'(filled_reg);

    assign m_rank            = rank_wide[RANK_W-1:0];
    assign m_result_id       = cell_id[0];
    assign m_result_distance = cell_dist[0];
    assign m_found_count     = found_wide[FOUND_W-1:0];
    assign m_final_of_run    = m_valid && last_out;

    // readout always reports at least one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (filled_reg != '0))
        else $error("readout with an empty list");

    // input and output sides never open together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input open during readout");

    // the item that ends a pass starts readout at rank zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_last) |=> (m_valid && rank_reg == '0))
        else $error("readout did not start after last item");

    // the final result item clears the list and reopens the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_final_of_run) |=> (s_ready && filled_reg == '0))
        else $error("list not cleared after readout");

    // fill level never passes the list depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(filled_reg) <= 32'(LIST_DEPTH))
        else $error("fill level beyond list depth");

endmodule : top_k_nearest_sorted_select
`default_nettype wire

>>> design/tkns_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tkns_cell: one slot of the sorted list
// compares the broadcast item with its own entry and takes the item, the
// neighbor's entry or keeps its own
// ---------------------------------------------------------------------------
module tkns_cell
    import tkns_pkg::*;
#(
    parameter int ID_WIDTH = DEFAULT_ID_WIDTH
) (
    input  wire                aclk,
    input  wire cell_ctrl_t    ctrl,
    input  wire [DIST_W-1:0]   cand_dist,
    input  wire [ID_WIDTH-1:0] cand_id,
    input  wire                prev_gt,
    input  wire [DIST_W-1:0]   prev_dist,
    input  wire [ID_WIDTH-1:0] prev_id,
    input  wire [DIST_W-1:0]   next_dist,
    input  wire [ID_WIDTH-1:0] next_id,
    output logic               gt,
    output logic [DIST_W-1:0]  held_dist,
    output logic [ID_WIDTH-1:0] id
);

    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;

    // item belongs at or ahead of this slot
    always_comb begin
        if (!ctrl.occupied) begin
            gt = 1'b1;
        end else if (ctrl.worst_full) begin
            gt = (cand_dist <= dist_reg);
        end else begin
            gt = (cand_dist < dist_reg);
        end
    end

    always_comb begin
        dist_next = dist_reg;
        id_next   = id_reg;
        if (ctrl.ins_en) begin
            if (gt && prev_gt) begin
                dist_next = prev_dist;
                id_next   = prev_id;
            end else if (gt) begin
                dist_next = cand_dist;
                id_next   = cand_id;
            end
        end else if (ctrl.shift_up) begin
            dist_next = next_dist;
            id_next   = next_id;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
        id_reg   <= id_next;
    end

    assign held_dist = dist_reg;
    assign id        = id_reg;

endmodule : tkns_cell
`default_nettype wire

>>> sim/top_k_nearest_sorted_select_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// top_k_nearest_sorted_select_tb: self-checking bench of the top-k selector
// streams passes of candidates through the block, rebuilds the sorted list
// with its own insertion model and checks every readout entry field by field
// ---------------------------------------------------------------------------
module top_k_nearest_sorted_select_tb
    import tkns_pkg::*;
();

    localparam int LIST_DEPTH     = DEFAULT_LIST_DEPTH;
    localparam int ID_W           = DEFAULT_ID_WIDTH;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int DRAIN_CYCLES   = 4;     // settle time before a keep_count write
    localparam int TAIL_CYCLES    = 20;    // quiet time at the end of the run

    // one readout entry as the block should report it
    typedef struct {
        logic [RANK_W-1:0]  rank;
        logic [ID_W-1:0]    id;
        logic [DIST_W-1:0]  distance;
        logic [FOUND_W-1:0] found;
        logic               last_of_run;
    } ranked_entry_t;

    // clock, reset and block ports
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [KEEP_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ID_W-1:0]      s_candidate_id = '0;
    logic [DIST_W-1:0]    s_distance = '0;
    logic                 s_last = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [RANK_W-1:0]    m_rank;
    logic [ID_W-1:0]      m_result_id;
    logic [DIST_W-1:0]    m_result_distance;
    logic [FOUND_W-1:0]   m_found_count;
    logic                 m_final_of_run;

    // idle mix of both sides, in percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // bookkeeping
    int unsigned error_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned passes_done    = 0;
    int unsigned results_seen   = 0;
    int unsigned keep_writes    = 0;
    int unsigned stall_cycles   = 0;

    // shadow of the sorted list and of keep_count
    logic [DIST_W-1:0]  near_dist [LIST_DEPTH];
    logic [ID_W-1:0]    near_id   [LIST_DEPTH];
    int unsigned        near_filled;
    logic [KEEP_W-1:0]  near_keep;

    // readout entries still owed by the block, oldest first
    ranked_entry_t expected_ranks[$];

    top_k_nearest_sorted_select #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_WIDTH   (ID_W)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_candidate_id    (s_candidate_id),
        .s_distance        (s_distance),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rank            (m_rank),
        .m_result_id       (m_result_id),
        .m_result_distance (m_result_distance),
        .m_found_count     (m_found_count),
        .m_final_of_run    (m_final_of_run)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // insertion model of the sorted list
    // ------------------------------------------------------------------

    // keep_count as the list applies it: zero acts as one, capped at the depth
    function automatic int unsigned keep_limit();
        int unsigned k;
        k = 32'(near_keep);
        if (k == 0) k = 1;
        if (k > LIST_DEPTH) k = LIST_DEPTH;
        return k;
    endfunction

    function automatic void clear_nearest();
        for (int i = 0; i < LIST_DEPTH; i++) begin
            near_dist[i] = EMPTY_DIST;
            near_id[i]   = '0;
        end
        near_filled = 0;
    endfunction

    // place one candidate; a newer item never passes an equal distance
    function automatic void insert_nearest(logic [ID_W-1:0] id, logic [DIST_W-1:0] cand_dist);
        int unsigned k;
        int unsigned pos;
        k = keep_limit();
        // the all-ones code marks an empty slot, so inputs stop one below it
        if (cand_dist == EMPTY_DIST) cand_dist = CLAMP_DIST;
        if (near_filled > k) near_filled = k;
        if (near_filled < k) begin
            pos = near_filled;
            near_filled++;
        end else if (cand_dist <= near_dist[k-1]) begin
            // full list: an equal distance still evicts the worst entry
            pos = k - 1;
        end else begin
            return;
        end
        while (pos > 0 && cand_dist < near_dist[pos-1]) begin
            near_dist[pos] = near_dist[pos-1];
            near_id[pos]   = near_id[pos-1];
            pos--;
        end
        near_dist[pos] = cand_dist;
        near_id[pos]   = id;
    endfunction

    // last item of a pass: the whole list is owed in rank order, then cleared
    function automatic void queue_readout();
        ranked_entry_t e;
        for (int unsigned i = 0; i < near_filled; i++) begin
            e.rank        = i[RANK_W-1:0];
            e.id          = near_id[i];
            e.distance    = near_dist[i];
            e.found       = near_filled[FOUND_W-1:0];
            e.last_of_run = (i + 1 == near_filled);
            expected_ranks.push_back(e);
        end
        clear_nearest();
    endfunction

    // ------------------------------------------------------------------
    // result side: random backpressure and the scoreboard
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void check_field(string name, int unsigned rank,
                                        logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch at rank %0d: expected %0h, actual %0h",
                     $time, name, rank, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        ranked_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ranks.size() == 0) begin
                $display({"%0t ns: unexpected result item: expected none, ",
                          "actual rank %0d id %0h dist %0h"},
                         $time, m_rank, m_result_id, m_result_distance);
                error_count++;
            end else begin
                want = expected_ranks.pop_front();
                check_field("rank", 32'(want.rank), 32'(want.rank), 32'(m_rank));
                check_field("result_id", 32'(want.rank), 32'(want.id), 32'(m_result_id));
                check_field("result_distance", 32'(want.rank), want.distance,
                            m_result_distance);
                check_field("found_count", 32'(want.rank), 32'(want.found),
                            32'(m_found_count));
                check_field("final_of_run", 32'(want.rank), 32'(want.last_of_run),
                            32'(m_final_of_run));
            end
            results_seen++;
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // item and register drivers
    // ------------------------------------------------------------------

    // send one candidate; valid is left high so the next item can follow at once
    task automatic send_item(logic [ID_W-1:0] id, logic [DIST_W-1:0] cand_dist, logic last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_candidate_id <= id;
        s_distance     <= cand_dist;
        s_last         <= last;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        // item taken at this edge: update the shadow list
        insert_nearest(id, cand_dist);
        if (last) begin
            queue_readout();
            passes_done++;
        end
        items_sent++;
    endtask

    task automatic stop_items();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // keep_count changes only with the list empty and the readout drained
    task automatic write_keep(logic [KEEP_W-1:0] value);
        stop_items();
        while (expected_ranks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        near_keep = value;
        keep_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly spread values, some tiny ones for ties, some edge codes
    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(9)) inside
            [0:4]: return $urandom;
            [5:7]: return $urandom_range(15);
            8: begin
                case ($urandom_range(5))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return 32'h7FFF_FFFF;
                    3:       return 32'h8000_0000;
                    4:       return CLAMP_DIST;
                    default: return EMPTY_DIST;
                endcase
            end
            default: return $urandom_range(32'h7FFF_FFFF);
        endcase
    endfunction

    // extremes weighted in, any 5-bit code allowed
    function automatic logic [KEEP_W-1:0] pick_keep();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 5'd1;
            2:       return KEEP_RESET;
            3:       return '1;
            default: return KEEP_W'($urandom_range(31));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset keep_count, id and distance extremes, all-ones clamp
    task automatic test_field_extremes();
        send_item('0, '0, 1'b0);
        send_item('1, EMPTY_DIST, 1'b0);          // clamps, ties with the next
        send_item(16'h5555, CLAMP_DIST, 1'b0);
        send_item(16'hAAAA, 32'd1, 1'b0);
        send_item(16'h00FF, 32'h7FFF_FFFF, 1'b0);
        send_item(16'h1234, 32'h8000_0000, 1'b1);
        send_item(16'hBEEF, 32'h0000_0042, 1'b1); // pass of a single item
        stop_items();
    endtask

    // equal distances: older stays first, full list evicts its worst on a tie
    task automatic test_equal_distances();
        write_keep(5'd2);
        send_item(16'd1, 32'd9, 1'b0);
        send_item(16'd2, 32'd9, 1'b0);
        send_item(16'd3, 32'd9, 1'b0);
        send_item(16'd4, 32'd8, 1'b1);
        write_keep(5'd1);
        send_item(16'd5, 32'd10, 1'b0);
        send_item(16'd6, 32'd10, 1'b0);
        send_item(16'd7, 32'd5, 1'b0);
        send_item(16'd8, 32'd7, 1'b1);
        stop_items();
    endtask

    // keep_count zero acts as one, above the depth acts as the depth
    task automatic test_keep_limits();
        write_keep('0);
        send_item(16'h0101, 32'd3, 1'b0);
        send_item(16'h0202, 32'd2, 1'b1);
        write_keep('1);
        send_item(16'h0303, 32'd30, 1'b0);
        send_item(16'h0404, 32'd20, 1'b0);
        send_item(16'h0505, 32'd25, 1'b1);
        stop_items();
    endtask

    // random passes of random length, keep_count changed between some of them
    task automatic test_random_passes(int unsigned send_pct, int unsigned recv_pct,
                                      int unsigned item_budget);
        int unsigned sent;
        int unsigned len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_budget) begin
            if ($urandom_range(2) == 0) write_keep(pick_keep());
            // mostly short passes, now and then long enough to overflow the list
            len = ($urandom_range(5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            if (len > item_budget - sent) len = item_budget - sent;
            for (int unsigned i = 0; i < len; i++)
                send_item(ID_W'($urandom_range(16'hFFFF)), pick_distance(), i == len - 1);
            sent += len;
        end
        stop_items();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        near_keep = KEEP_RESET;
        clear_nearest();
        // synchronous reset held at the start, then released
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 48;
        test_field_extremes();
        test_equal_distances();
        test_keep_limits();

        test_random_passes(21, 48, 110);
        test_random_passes(48, 21, 110);
        test_random_passes(0, 0, 110);

        // let the last readout finish, then watch for stray results
        while (expected_ranks.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d items in %0d passes, %0d result items, %0d keep_count writes",
                 items_sent, passes_done, results_seen, keep_writes);
        $display("keep_count from 0 to 31, distance ties and clamp, three idle mixes");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
